### rtl/core/rtc_pkg.sv
// Shared types and constants for the rotamer transition counter.
// No dependencies; compiled first.
package rtc_pkg;

  localparam int BIN_BITS   = 2;
  localparam int TOTAL_BITS = 32;
  localparam int FOLD_MAX   = 3;
  localparam int FRAC_BITS  = 9;
  localparam int FRAC_ONE   = 256;
  localparam int CFG_DATA_BITS  = 9;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THREE_STATE   = 2'd0,
    CFG_FOLD_COUNT    = 2'd1,
    CFG_CORE_FRACTION = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic                 three_state_mode;
    logic [1:0]           fold_count;
    logic [FRAC_BITS-1:0] core_fraction;
  } cfg_t;

endpackage

### rtl/core/rtc_sample_if.sv
// Sample channel: one dihedral angle beat with its series-start flag.
// Depends on nothing but the ANGLE_BITS parameter.
interface rtc_sample_if #(
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle;
  logic                         first_sample;

  modport source (output valid, output angle, output first_sample, input ready);
  modport sink   (input valid, input angle, input first_sample, output ready);
endinterface

### rtl/core/rtc_result_if.sv
// Result channel: bin, transition flag and running counts for one sample.
// Uses rtc_pkg for the fixed field widths.
interface rtc_result_if import rtc_pkg::*; #(
  parameter int COUNT_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [BIN_BITS-1:0]   bin;
  logic                  transition;
  logic [COUNT_BITS-1:0] series_transitions;
  logic [COUNT_BITS-1:0] bin_occupancy;
  logic [TOTAL_BITS-1:0] total_transitions;

  modport source (output valid, output bin, output transition, output series_transitions,
                  output bin_occupancy, output total_transitions, input ready);
  modport sink   (input valid, input bin, input transition, input series_transitions,
                  input bin_occupancy, input total_transitions, output ready);
endinterface

### rtl/core/rtc_binner.sv
// Rotamer bin classifier: registered N-fold window bounds derived from the
// configuration, plus shallow compares on one angle. Uses rtc_pkg.
module rtc_binner import rtc_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  cfg_t                         cfg,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic [BIN_BITS-1:0]          bin
);

  localparam int WW = ANGLE_BITS + 1;   // sector width
  localparam int CB = ANGLE_BITS + 2;   // doubled-angle bound width
  localparam int PW = WW + FRAC_BITS;   // core product width
  localparam int SW = ANGLE_BITS + 5;   // room for 12 * angle

  localparam logic [WW-1:0] W_ONE   = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic [WW-1:0] W_TWO   = {2'b01, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [WW-1:0] W_THREE = WW'((longint'(1) << ANGLE_BITS) / 3);

  localparam logic signed [SW-1:0] POS_F  = SW'(longint'(1) << ANGLE_BITS);
  localparam logic signed [SW-1:0] NEG_F  = -POS_F;
  localparam logic signed [SW-1:0] POS_5F = SW'(5 * (longint'(1) << ANGLE_BITS));
  localparam logic signed [SW-1:0] NEG_5F = -POS_5F;

  // Window bounds, recomputed every cycle from the configuration registers
  logic [CB-1:0] lo_bound [FOLD_MAX];
  logic [CB-1:0] hi_bound [FOLD_MAX];
  logic [FOLD_MAX-1:0] fold_en;

  logic [WW-1:0]        width;
  logic [FRAC_BITS-1:0] frac_sat;
  logic [PW-1:0]        core_prod;
  logic [WW-1:0]        core;
  logic [CB-1:0]        center [FOLD_MAX];
  logic [FOLD_MAX-1:0]  fold_en_next;

  always_comb begin
    unique case (cfg.fold_count)
      2'd2:    width = W_TWO;
      2'd3:    width = W_THREE;
      default: width = W_ONE;   // zero folds behave as one
    endcase
    frac_sat  = (cfg.core_fraction > FRAC_BITS'(FRAC_ONE)) ? FRAC_BITS'(FRAC_ONE)
                                                           : cfg.core_fraction;
    core_prod = PW'(frac_sat) * PW'(width);
    core      = core_prod[PW-2:8];
    // bin b is centered at (2b-1) * width on the doubled angle
    center[0] = CB'(width);
    center[1] = CB'(width) + (CB'(width) << 1);
    center[2] = CB'(width) + (CB'(width) << 2);
    fold_en_next[0] = 1'b1;
    fold_en_next[1] = (cfg.fold_count >= 2'd2);
    fold_en_next[2] = (cfg.fold_count == 2'd3);
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < FOLD_MAX; b++) begin
      lo_bound[b] <= center[b] - CB'(core);
      hi_bound[b] <= center[b] + CB'(core);
    end
    fold_en <= fold_en_next;
  end

  logic [CB-1:0]        u2;
  logic [FOLD_MAX-1:0]  hit;
  logic signed [SW-1:0] s_ext;
  logic signed [SW-1:0] s4;
  logic signed [SW-1:0] s12;
  logic [BIN_BITS-1:0]  nfold_bin;
  logic [BIN_BITS-1:0]  three_bin;

  always_comb begin
    u2 = {1'b0, $unsigned(angle), 1'b0};
    for (int b = 0; b < FOLD_MAX; b++) begin
      hit[b] = fold_en[b] && (u2 > lo_bound[b]) && (u2 < hi_bound[b]);
    end
    priority if (hit[0]) nfold_bin = BIN_BITS'(1);
    else if (hit[1])     nfold_bin = BIN_BITS'(2);
    else if (hit[2])     nfold_bin = BIN_BITS'(3);
    else                 nfold_bin = '0;

    s_ext = {{(SW-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle};
    s4    = s_ext <<< 2;
    s12   = (s_ext <<< 3) + (s_ext <<< 2);
    priority if ((s12 < POS_F) && (s12 > NEG_F))   three_bin = BIN_BITS'(1);
    else if ((s12 > NEG_5F) && (s4 < NEG_F))       three_bin = BIN_BITS'(2);
    else if ((s4 > POS_F) && (s12 < POS_5F))       three_bin = BIN_BITS'(3);
    else                                           three_bin = '0;

    bin = cfg.three_state_mode ? three_bin : nfold_bin;
  end

endmodule

### rtl/core/rotamer_transition_counter.sv
// Rotamer transition counter top level: config registers, sample register,
// per-series/overall counters and result register. Uses rtc_pkg, rtc_binner.
//
//  channel  | dir | payload                                        | handshake
//  samples  | in  | angle, first_sample                            | valid/ready
//  results  | out | bin, transition, series_transitions,           | valid/ready
//           |     | bin_occupancy, total_transitions               |
//  cfg      | in  | cfg_index, cfg_data                            | cfg_wr_en
//
// Sample then result register; one sample per cycle unless results stall.
// The per-sample path is the bin compare plus one counter update and the
// saturating increments, between the sample register and the result register.
// rst is synchronous: clears counters, held bin and pipeline valids, and loads
// the default configuration. A stalled result holds the sample register, and
// samples stall only when both stages are full, and during reset.
module rotamer_transition_counter import rtc_pkg::*; #(
  parameter int ROTAMER_BINS = 4,
  parameter int COUNT_BITS   = 20,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  rtc_sample_if.sink                samples,
  rtc_result_if.source              results,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IDX_BITS = $clog2(ROTAMER_BINS);

  // configuration
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.three_state_mode <= 1'b0;
      cfg.fold_count       <= 2'd3;
      cfg.core_fraction    <= FRAC_BITS'(128);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_THREE_STATE:   cfg.three_state_mode <= cfg_data[0];
        CFG_FOLD_COUNT:    cfg.fold_count       <= cfg_data[1:0];
        CFG_CORE_FRACTION: cfg.core_fraction    <= cfg_data[FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sample register
  logic                         s1_valid;
  logic signed [ANGLE_BITS-1:0] s1_angle;
  logic                         s1_first;
  logic                         advance;

  assign advance       = s1_valid && (!results.valid || results.ready);
  assign samples.ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      s1_angle <= samples.angle;
      s1_first <= samples.first_sample;
    end
  end

  logic [BIN_BITS-1:0] bin;

  rtc_binner #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_binner (
    .clk  (clk),
    .cfg  (cfg),
    .angle(s1_angle),
    .bin  (bin)
  );

  // series and overall state
  logic [BIN_BITS-1:0]   held_bin;
  logic [COUNT_BITS-1:0] series_count;
  logic [COUNT_BITS-1:0] occupancy [ROTAMER_BINS];
  logic [TOTAL_BITS-1:0] total_count;

  logic                  trans;
  logic [BIN_BITS-1:0]   held_bin_next;
  logic [COUNT_BITS-1:0] series_count_next;
  logic [TOTAL_BITS-1:0] total_count_next;
  logic [IDX_BITS-1:0]   idx;
  logic [COUNT_BITS-1:0] occ_sel;
  logic [COUNT_BITS-1:0] occ_next;

  always_comb begin
    trans = !s1_first && (held_bin != '0) && (bin != '0) && (bin != held_bin);
    held_bin_next = (s1_first || (held_bin == '0) || trans) ? bin : held_bin;

    if (s1_first) begin
      series_count_next = '0;
    end else if (trans && (series_count != '1)) begin
      series_count_next = series_count + COUNT_BITS'(1);
    end else begin
      series_count_next = series_count;
    end

    if (trans && (total_count != '1)) begin
      total_count_next = total_count + TOTAL_BITS'(1);
    end else begin
      total_count_next = total_count;
    end

    idx      = IDX_BITS'(bin);
    occ_sel  = s1_first ? '0 : occupancy[idx];   // new series starts from zero
    occ_next = (occ_sel == '1) ? occ_sel : occ_sel + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bin     <= '0;
      series_count <= '0;
      total_count  <= '0;
      for (int i = 0; i < ROTAMER_BINS; i++) begin
        occupancy[i] <= '0;
      end
    end else if (advance) begin
      held_bin     <= held_bin_next;
      series_count <= series_count_next;
      total_count  <= total_count_next;
      for (int i = 0; i < ROTAMER_BINS; i++) begin
        if (IDX_BITS'(i) == idx) begin
          occupancy[i] <= occ_next;
        end else if (s1_first) begin
          occupancy[i] <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (advance) begin
      results.bin                <= bin;
      results.transition         <= trans;
      results.series_transitions <= series_count_next;
      results.bin_occupancy      <= occ_next;
      results.total_transitions  <= total_count_next;
    end
  end

endmodule

### tb/tb_rotamer_transition_counter.sv
// Testbench for rotamer_transition_counter: streams dihedral samples with random
// idling on both channels and checks every result beat against a predictor.
// Depends on rtc_pkg, rtc_sample_if, rtc_result_if and the RTL top level.
module tb_rotamer_transition_counter import rtc_pkg::*;;

  localparam int ANGLE_W = 16;
  localparam int COUNT_W = 20;
  localparam int BIN_SLOTS = 4;
  localparam longint FULL_TURN = longint'(1) << ANGLE_W;
  localparam int CLK_PERIOD = 8;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 64;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_PRINTED = 30;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_MIXED} idle_mode_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]   bin;
    logic                  transition;
    logic [COUNT_W-1:0]    series_transitions;
    logic [COUNT_W-1:0]    bin_occupancy;
    logic [TOTAL_BITS-1:0] total_transitions;
  } rotamer_result_t;

  class transition_tally;
    cfg_t                  regs;
    logic [BIN_BITS-1:0]   held_bin;
    logic [COUNT_W-1:0]    series_count;
    logic [COUNT_W-1:0]    occupancy [BIN_SLOTS];
    logic [TOTAL_BITS-1:0] overall_count;
    rotamer_result_t       pending_results [$];
    int                    mismatches;

    function new();
      regs = '{three_state_mode: 1'b0, fold_count: 2'd3, core_fraction: 9'd128};
      held_bin = '0;
      series_count = '0;
      foreach (occupancy[k]) occupancy[k] = '0;
      overall_count = '0;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                               logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_THREE_STATE:   regs.three_state_mode = data[0];
        CFG_FOLD_COUNT:    regs.fold_count = data[1:0];
        CFG_CORE_FRACTION: regs.core_fraction = data;
        default: ;
      endcase
    endfunction

    // fold count of zero behaves as one sector
    function int fold_total();
      return (regs.fold_count == 0) ? 1 : int'(regs.fold_count);
    endfunction

    // doubled open bounds of the core window of sector b
    function void sector_edges(int b, output longint lo2, output longint hi2);
      longint w, c, frac;
      frac = (regs.core_fraction > FRAC_ONE) ? FRAC_ONE : longint'(regs.core_fraction);
      w = FULL_TURN / fold_total();
      c = (frac * w) / FRAC_ONE;
      lo2 = 2 * (b - 1) * w + (w - c);
      hi2 = lo2 + 2 * c;
    endfunction

    function logic [BIN_BITS-1:0] sector_bin(logic signed [ANGLE_W-1:0] angle);
      longint u2, lo2, hi2;
      int b;
      u2 = 2 * longint'($unsigned(angle));
      for (b = 1; b <= fold_total(); b++) begin
        sector_edges(b, lo2, hi2);
        if (u2 > lo2 && u2 < hi2) return BIN_BITS'(b);
      end
      return '0;
    endfunction

    function logic [BIN_BITS-1:0] three_state_bin(logic signed [ANGLE_W-1:0] angle);
      longint s;
      s = angle;
      if (12 * s < FULL_TURN && 12 * s > -FULL_TURN) return 2'd1;
      if (12 * s > -5 * FULL_TURN && 4 * s < -FULL_TURN) return 2'd2;
      if (4 * s > FULL_TURN && 12 * s < 5 * FULL_TURN) return 2'd3;
      return 2'd0;
    endfunction

    function void note_sample(logic signed [ANGLE_W-1:0] angle, logic first);
      rotamer_result_t r;
      logic [BIN_BITS-1:0] b;
      b = regs.three_state_mode ? three_state_bin(angle) : sector_bin(angle);
      r.transition = 1'b0;
      if (first) begin
        series_count = '0;
        foreach (occupancy[k]) occupancy[k] = '0;
        held_bin = b;
      end else if (held_bin == 0) begin
        held_bin = b;
      end else if (b != 0 && b != held_bin) begin
        held_bin = b;
        r.transition = 1'b1;
        if (series_count != '1) series_count++;
        if (overall_count != '1) overall_count++;
      end
      if (occupancy[b] != '1) occupancy[b]++;
      r.bin = b;
      r.series_transitions = series_count;
      r.bin_occupancy = occupancy[b];
      r.total_transitions = overall_count;
      pending_results.push_back(r);
    endfunction

    task check_result(rotamer_result_t got);
      rotamer_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with no sample pending");
        return;
      end
      want = pending_results.pop_front();
      if (got.bin !== want.bin)
        report($sformatf("bin %0d, wanted %0d", got.bin, want.bin));
      if (got.transition !== want.transition)
        report($sformatf("transition %0b, wanted %0b", got.transition, want.transition));
      if (got.series_transitions !== want.series_transitions)
        report($sformatf("series_transitions %0d, wanted %0d",
                         got.series_transitions, want.series_transitions));
      if (got.bin_occupancy !== want.bin_occupancy)
        report($sformatf("bin_occupancy %0d, wanted %0d",
                         got.bin_occupancy, want.bin_occupancy));
      if (got.total_transitions !== want.total_transitions)
        report($sformatf("total_transitions %0d, wanted %0d",
                         got.total_transitions, want.total_transitions));
    endtask

    task flush_leftovers();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  rtc_sample_if #(.ANGLE_BITS(ANGLE_W)) samples_ch ();
  rtc_result_if #(.COUNT_BITS(COUNT_W)) results_ch ();

  rotamer_transition_counter #(
    .ROTAMER_BINS(BIN_SLOTS),
    .COUNT_BITS(COUNT_W),
    .ANGLE_BITS(ANGLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_ch),
    .results(results_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  transition_tally tally = new();
  idle_mode_t sender_idle = IDLE_SHORT;
  idle_mode_t receiver_idle = IDLE_SHORT;
  bit hold_request = 1'b0;

  // reset config, no series started yet: held-zero start, core edges, wrap,
  // bin-zero samples between cores, and a series restart into bin zero
  int default_sweep_angle [14] = '{0, 10000, 30000, -32768, 32767, 20000, -10000,
                                   5461, 5462, 30000, -1, 10000, 0, -10000};
  bit default_sweep_first [14] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0};
  // three-state borders at 30, 90 and 150 degrees, both sides of each
  int three_state_sweep [12] = '{5461, 5462, -5461, -5462, -16384, -16385,
                                 -27306, -27307, 16384, 16385, 27306, 27307};
  int ts_edges [6] = '{5461, -5461, -16384, -27306, 16384, 27306};

  bit phase_mode [10] = '{0, 0, 0, 0, 0, 1, 0, 0, 1, 0};
  int phase_fold [10] = '{3, 1, 2, 0, 3, 2, 1, 3, 0, 2};
  int phase_frac [10] = '{128, 256, 0, 64, 511, 257, 1, 255, 300, 200};

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic int pick_gap(idle_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == IDLE_NONE || roll < 60) return 0;
    if (mode == IDLE_SHORT || roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly core and near-border angles so that series actually move between bins
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int roll, b, pick;
    longint lo2, hi2;
    roll = $urandom_range(0, 99);
    if (roll < 30) return ANGLE_W'($urandom);
    if (tally.regs.three_state_mode) begin
      if (roll >= 65)
        return ANGLE_W'(ts_edges[$urandom_range(0, 5)] + int'($urandom_range(0, 6)) - 3);
      b = $urandom_range(1, 3);
      if (b == 1) return ANGLE_W'(int'($urandom_range(0, 10922)) - 5461);
      if (b == 2) return ANGLE_W'(-int'($urandom_range(16385, 27306)));
      return ANGLE_W'($urandom_range(16385, 27306));
    end
    b = $urandom_range(1, tally.fold_total());
    tally.sector_edges(b, lo2, hi2);
    if (roll < 65)
      pick = int'(lo2 / 2) + int'($urandom_range(0, int'((hi2 - lo2) / 2) + 1));
    else
      pick = int'(((roll % 2) ? lo2 : hi2) / 2) + int'($urandom_range(0, 6)) - 3;
    return ANGLE_W'(pick);
  endfunction

  task automatic send_sample(input logic signed [ANGLE_W-1:0] angle, input logic first,
                             input int gap);
    samples_ch.valid <= 1'b1;
    samples_ch.angle <= angle;
    samples_ch.first_sample <= first;
    do @(posedge clk); while (!samples_ch.ready);
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_wait();
    samples_ch.valid <= 1'b0;
    @(posedge clk);
    while (tally.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tally.set_register(idx, data);
  endtask

  // upper data bits are junk on the narrow registers; they must be dropped
  task automatic load_config(input bit mode, input int fold, input int frac,
                             input bit touch_spare);
    if (touch_spare) write_register(CFG_SPARE, 9'($urandom));
    write_register(CFG_THREE_STATE, {8'($urandom), mode});
    write_register(CFG_FOLD_COUNT, {7'($urandom), 2'(fold)});
    write_register(CFG_CORE_FRACTION, 9'(frac));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int p, i, fold, frac;
    bit mode, pressure, pause;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.angle <= '0;
    samples_ch.first_sample <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (default_sweep_angle[k])
      send_sample(ANGLE_W'(default_sweep_angle[k]), default_sweep_first[k],
                  pick_gap(IDLE_SHORT));
    drain_wait();
    load_config(1'b1, 3, 128, 1'b1);
    foreach (three_state_sweep[k])
      send_sample(ANGLE_W'(three_state_sweep[k]), k == 0, pick_gap(IDLE_SHORT));

    for (p = 0; p < PHASES; p++) begin
      drain_wait();
      if (p < 10) begin
        mode = phase_mode[p];
        fold = phase_fold[p];
        frac = phase_frac[p];
      end else begin
        mode = $urandom_range(0, 1);
        fold = $urandom_range(0, 3);
        frac = $urandom_range(0, 511);
      end
      load_config(mode, fold, frac, (p % 3) == 0);
      pressure = (p == 4) || (p == 9);
      pause = (p == 2) || (p == 7);
      sender_idle = (p == 1 || pressure) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      receiver_idle = (p == 1) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // receiver goes quiet while beats keep coming, so the input backs up
        if (pressure && i == 40) hold_request = 1'b1;
        if (pause && i == 80) drain_wait();
        send_sample(pick_angle(), $urandom_range(0, 31) == 0, pick_gap(sender_idle));
      end
    end

    drain_wait();
    tally.flush_leftovers();
    if (tally.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : result_drain
    int stall;
    results_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = pick_gap(receiver_idle);
        if (stall > 0) begin
          results_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      results_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : beat_watch
    rotamer_result_t seen;
    if (!rst) begin
      if (samples_ch.valid && samples_ch.ready)
        tally.note_sample(samples_ch.angle, samples_ch.first_sample);
      if (results_ch.valid && results_ch.ready) begin
        seen = '{bin: results_ch.bin,
                 transition: results_ch.transition,
                 series_transitions: results_ch.series_transitions,
                 bin_occupancy: results_ch.bin_occupancy,
                 total_transitions: results_ch.total_transitions};
        tally.check_result(seen);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
